/* rtl/pofc_pkg.sv */
package pofc_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned MixerBits   = 32;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 6;
  localparam int unsigned ChanW       = 4;
  localparam int unsigned ShiftW      = 5;

  typedef logic signed [MixerBits-1:0] sample_t;
  typedef logic        [MixerBits-1:0] word_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDeviceChannels = 3'd0,
    CfgBytesPerSample = 3'd1,
    CfgMsbAligned     = 3'd2,
    CfgSignificantBits = 3'd3,
    CfgSignedFormat   = 3'd4,
    CfgSwapBytes      = 3'd5
  } cfg_reg_e;

endpackage

/* rtl/pofc_if.sv */
interface pofc_in_if;
  logic              valid;
  logic              ready;
  pofc_pkg::sample_t mixer_sample;

  modport source (output valid, output mixer_sample, input ready);
  modport sink (input valid, input mixer_sample, output ready);
endinterface

interface pofc_out_if;
  logic            valid;
  logic            ready;
  pofc_pkg::word_t device_word;
  logic            last_in_frame;

  modport source (output valid, output device_word, output last_in_frame, input ready);
  modport sink (input valid, input device_word, input last_in_frame, output ready);
endinterface

/* rtl/pcm_output_format_converter.sv */
// PCM output format converter. Takes one channel-interleaved 32-bit mixer sample per
// transfer on mix_i and gives one device word per device channel on dev_o. A sample
// goes through an input register, then one pass of shift, bias add, pair averaging and
// byte packing into the result register. One sample is taken every cycle as long as
// dev_o keeps up; when the result register stalls, the input register holds its sample
// too. With an odd device channel count the mixer frame has one extra channel and the
// last two are averaged into a single word, so that frame gives one word fewer than it
// takes samples. The user must write configuration through cfg_we_i only while no
// sample is in flight; the block itself does not enforce this.
module pcm_output_format_converter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pofc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pofc_pkg::CfgDataW-1:0]       cfg_data_i,
  pofc_in_if.sink                             mix_i,
  pofc_out_if.source                          dev_o
);

  // configuration
  logic [3:0] dev_chan_q;
  logic [2:0] bytes_q;
  logic       msb_q;
  logic [5:0] sig_bits_q;
  logic       signed_q;
  logic       swap_q;

  // input register
  logic              in_vq;
  pofc_pkg::sample_t in_sample_q;

  // frame state
  logic [pofc_pkg::ChanW-1:0] pos_q, pos_d;
  pofc_pkg::word_t            held_q, held_d;

  // result register
  logic              out_vq, out_vd;
  pofc_pkg::word_t   out_word_q, out_word_d;
  logic              out_last_q, out_last_d;

  logic out_free, in_fire, stage_fire;

  // datapath
  logic [3:0]                  dev_eff;
  logic [3:0]                  mix_len;
  logic                        odd_cnt;
  logic [pofc_pkg::ChanW-1:0]  pos_eff;
  logic [2:0]                  bps_eff;
  logic [5:0]                  bits_eff;
  logic [5:0]                  shift_full;
  logic [pofc_pkg::ShiftW-1:0] shift;
  pofc_pkg::word_t             bias;
  pofc_pkg::word_t             conv;
  pofc_pkg::word_t             half_conv;
  pofc_pkg::word_t             pre_pack;
  pofc_pkg::word_t             masked;
  pofc_pkg::word_t             swapped;
  logic                        pair_first, pair_last, emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_chan_q <= 4'd2;
      bytes_q    <= 3'd4;
      msb_q      <= 1'b1;
      sig_bits_q <= 6'd32;
      signed_q   <= 1'b1;
      swap_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pofc_pkg::CfgDeviceChannels:  dev_chan_q <= cfg_data_i[3:0];
        pofc_pkg::CfgBytesPerSample:  bytes_q    <= cfg_data_i[2:0];
        pofc_pkg::CfgMsbAligned:      msb_q      <= cfg_data_i[0];
        pofc_pkg::CfgSignificantBits: sig_bits_q <= cfg_data_i[5:0];
        pofc_pkg::CfgSignedFormat:    signed_q   <= cfg_data_i[0];
        pofc_pkg::CfgSwapBytes:       swap_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on whenever the result register frees up
  assign out_free    = !out_vq || dev_o.ready;
  assign stage_fire  = in_vq && out_free;
  assign mix_i.ready = !in_vq || out_free;
  assign in_fire     = mix_i.valid && mix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (mix_i.ready) begin
      in_vq <= mix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_sample_q <= mix_i.mixer_sample;
    end
  end

  // frame geometry
  always_comb begin
    if (dev_chan_q == 4'd0) begin
      dev_eff = 4'd1;
    end else if (dev_chan_q > 4'(pofc_pkg::MaxChannels)) begin
      dev_eff = 4'(pofc_pkg::MaxChannels);
    end else begin
      dev_eff = dev_chan_q;
    end
    odd_cnt = dev_eff[0];
    mix_len = odd_cnt ? dev_eff + 4'd1 : dev_eff;
    pos_eff = (pos_q >= mix_len) ? '0 : pos_q;
    pair_first = odd_cnt && (pos_eff == mix_len - 4'd2);
    pair_last  = odd_cnt && (pos_eff == mix_len - 4'd1);
    emit       = !pair_first;
    pos_d      = (pos_eff + 4'd1 >= mix_len) ? '0 : pos_eff + 4'd1;
  end

  // shift, bias and halving
  always_comb begin
    if (bytes_q == 3'd0) begin
      bps_eff = 3'd1;
    end else if (bytes_q > 3'd4) begin
      bps_eff = 3'd4;
    end else begin
      bps_eff = bytes_q;
    end
    if (sig_bits_q == 6'd0) begin
      bits_eff = 6'd1;
    end else if (sig_bits_q > 6'(pofc_pkg::MixerBits)) begin
      bits_eff = 6'(pofc_pkg::MixerBits);
    end else begin
      bits_eff = sig_bits_q;
    end
    shift_full = msb_q ? 6'(pofc_pkg::MixerBits) - {bps_eff, 3'b000}
                       : 6'(pofc_pkg::MixerBits) - bits_eff;
    shift      = shift_full[pofc_pkg::ShiftW-1:0];
    bias       = signed_q ? '0 : (32'h8000_0000 >> shift);
    conv       = pofc_pkg::word_t'(in_sample_q >>> shift) + bias;
    // halve with truncation toward zero
    half_conv  = {conv[31], conv[31:1]} + {31'd0, conv[31] & conv[0]};
    held_d     = half_conv;
    pre_pack   = pair_last ? held_q + half_conv : conv;
  end

  // byte packing
  always_comb begin
    masked  = pre_pack;
    swapped = pre_pack;
    case (bps_eff)
      3'd1: begin
        masked  = {24'd0, pre_pack[7:0]};
        swapped = masked;
      end
      3'd2: begin
        masked  = {16'd0, pre_pack[15:0]};
        swapped = {16'd0, pre_pack[7:0], pre_pack[15:8]};
      end
      3'd3: begin
        masked  = {8'd0, pre_pack[23:0]};
        swapped = {8'd0, pre_pack[7:0], pre_pack[15:8], pre_pack[23:16]};
      end
      default: begin
        masked  = pre_pack;
        swapped = {pre_pack[7:0], pre_pack[15:8], pre_pack[23:16], pre_pack[31:24]};
      end
    endcase
    out_word_d = swap_q ? swapped : masked;
    out_last_d = pos_eff == mix_len - 4'd1;
    out_vd     = out_free ? (stage_fire && emit) : out_vq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      held_q <= '0;
      out_vq <= 1'b0;
    end else begin
      out_vq <= out_vd;
      if (stage_fire) begin
        pos_q <= pos_d;
        if (pair_first) begin
          held_q <= held_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_fire && emit) begin
      out_word_q <= out_word_d;
      out_last_q <= out_last_d;
    end
  end

  assign dev_o.valid         = out_vq;
  assign dev_o.device_word   = out_word_q;
  assign dev_o.last_in_frame = out_last_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < 4'(pofc_pkg::MaxChannels))
    else $error("channel position beyond largest frame");

  a_pair_first_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_fire && pair_first) |=> !out_vq)
    else $error("first sample of averaged pair produced a word");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mix_i.ready |-> (in_vq && out_vq && !dev_o.ready))
    else $error("input stalled without a blocked result");

  a_result_after_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vq) |-> $past(stage_fire))
    else $error("result appeared without a processed sample");

endmodule
